/* sv/spi_adc_channel_scanner_core_defines.svh */
// Assertion macros used by the scanner top level.
`ifndef SPI_ADC_CHANNEL_SCANNER_CORE_DEFINES_SVH
`define SPI_ADC_CHANNEL_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/scn_pkg.sv */
// Types and constants shared by the serial converter channel scanner.
package scn_pkg;

    // Sequencing constants.
    localparam int CHANNELS        = 4;
    localparam int CMD_BITS        = 8;
    localparam int DATA_START      = 12;
    localparam int CLOCKS_PER_READ = 24;
    localparam int DATA_BITS       = 12;

    // Field widths.
    localparam int CH_W      = 2;
    localparam int CMD_W     = 8;
    localparam int RAW_W     = 12;
    localparam int SCALE_W   = 32;
    localparam int SCALED_W  = 44;
    localparam int MAP_W     = 4;
    localparam int NUM_CMD   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int CNT_W     = $clog2(CLOCKS_PER_READ + 1);

    // Reset values.
    localparam logic [MAP_W-1:0]     CHIP_MAP_RESET = MAP_W'(12);
    localparam logic [DATA_BITS-1:0] MASK_INIT      = DATA_BITS'(1) << (DATA_BITS - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LSB_SCALE   = 3'd0,
        REG_CHIP_MAP    = 3'd1,
        REG_COMMAND_CH0 = 3'd2,
        REG_COMMAND_CH1 = 3'd3,
        REG_COMMAND_CH2 = 3'd4,
        REG_COMMAND_CH3 = 3'd5
    } cfg_reg_t;

    // Sequencer phases, one-hot.
    typedef enum logic [5:0] {
        PH_START   = 6'b000001,
        PH_SELECT  = 6'b000010,
        PH_CLOCK   = 6'b000100,
        PH_RELEASE = 6'b001000,
        PH_REPORT  = 6'b010000,
        PH_ADVANCE = 6'b100000
    } phase_t;

    // Configuration as seen by the sequencer and the scaler.
    typedef struct packed {
        logic [SCALE_W-1:0]            lsb_scale;
        logic [MAP_W-1:0]              chip_map;
        logic [NUM_CMD-1:0][CMD_W-1:0] command;
    } cfg_t;

    // Outcome of one sequencer tick, before scaling.
    typedef struct packed {
        logic             chip0_select_n;
        logic             chip1_select_n;
        logic             mosi_level;
        logic             clock_pulse;
        logic             reading_valid;
        logic [CH_W-1:0]  channel_index;
        logic [RAW_W-1:0] raw_reading;
    } tick_t;

endpackage

/* sv/scn_cfg.sv */
// Configuration register file of the scanner.
module scn_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scn_pkg::CFG_DAT_W-1:0]    cfg_data,
    output scn_pkg::cfg_t                    cfg
);
    import scn_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes beyond the list change nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LSB_SCALE:   cfg_next.lsb_scale  = cfg_data[SCALE_W-1:0];
                REG_CHIP_MAP:    cfg_next.chip_map   = cfg_data[MAP_W-1:0];
                REG_COMMAND_CH0: cfg_next.command[0] = cfg_data[CMD_W-1:0];
                REG_COMMAND_CH1: cfg_next.command[1] = cfg_data[CMD_W-1:0];
                REG_COMMAND_CH2: cfg_next.command[2] = cfg_data[CMD_W-1:0];
                REG_COMMAND_CH3: cfg_next.command[3] = cfg_data[CMD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lsb_scale <= '0;
            cfg_reg.chip_map  <= CHIP_MAP_RESET;
            cfg_reg.command   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/scn_seq.sv */
// Round-robin serial read sequencer: takes one step per tick; the clock phase repeats until the read is done.
module scn_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           miso,
    input  scn_pkg::cfg_t  cfg,
    output scn_pkg::tick_t tick
);
    import scn_pkg::*;

    phase_t               phase_reg,   phase_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [CMD_W-1:0]     cmd_sh_reg,  cmd_sh_next;
    logic [DATA_BITS-1:0] acc_reg,     acc_next;
    logic [DATA_BITS-1:0] mask_reg,    mask_next;
    logic [CH_W-1:0]      chan_reg,    chan_next;
    logic [1:0]           sel_reg,     sel_next;
    logic                 chip_reg,    chip_next;
    logic [CNT_W-1:0]     bit_cnt_inc;

    assign bit_cnt_inc = bit_cnt_reg + CNT_W'(1);

    // Next state and the outputs of this tick.
    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd_sh_next  = cmd_sh_reg;
        acc_next     = acc_reg;
        mask_next    = mask_reg;
        chan_next    = chan_reg;
        sel_next     = sel_reg;
        chip_next    = chip_reg;

        tick.mosi_level    = 1'b0;
        tick.clock_pulse   = 1'b0;
        tick.reading_valid = 1'b0;
        tick.channel_index = '0;
        tick.raw_reading   = '0;

        case (phase_reg)
            PH_SELECT:
            begin
                sel_next   = chip_reg ? (sel_reg & 2'b01) : (sel_reg & 2'b10);
                phase_next = PH_CLOCK;
            end
            PH_CLOCK:
            begin
                tick.clock_pulse = 1'b1;
                if (int'(bit_cnt_reg) < CMD_BITS)
                begin
                    tick.mosi_level = cmd_sh_reg[CMD_W-1];
                    cmd_sh_next     = cmd_sh_reg << 1;
                end
                // Bits are disjoint, so adding the mask is an OR.
                if (int'(bit_cnt_reg) >= DATA_START)
                begin
                    if (miso)
                    begin
                        acc_next = acc_reg | mask_reg;
                    end
                    mask_next = mask_reg >> 1;
                end
                bit_cnt_next = bit_cnt_inc;
                if (bit_cnt_inc >= CNT_W'(CLOCKS_PER_READ))
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                sel_next   = 2'b11;
                phase_next = PH_REPORT;
            end
            PH_REPORT:
            begin
                tick.reading_valid = 1'b1;
                tick.channel_index = chan_reg;
                tick.raw_reading   = RAW_W'(acc_reg);
                phase_next         = PH_ADVANCE;
            end
            PH_ADVANCE:
            begin
                chan_next = chan_reg + CH_W'(1);
                if (int'(chan_next) >= CHANNELS)
                begin
                    chan_next = '0;
                end
                phase_next = PH_START;
            end
            default:
            begin
                // Start tick, and any unused code: latch command and chip.
                cmd_sh_next  = cfg.command[chan_reg];
                chip_next    = cfg.chip_map[chan_reg];
                acc_next     = '0;
                mask_next    = MASK_INIT;
                bit_cnt_next = '0;
                phase_next   = PH_SELECT;
            end
        endcase

        tick.chip0_select_n = sel_next[0];
        tick.chip1_select_n = sel_next[1];
    end

    // Sequencer state, updated once per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            bit_cnt_reg <= '0;
            cmd_sh_reg  <= '0;
            acc_reg     <= '0;
            mask_reg    <= MASK_INIT;
            chan_reg    <= '0;
            sel_reg     <= 2'b11;
            chip_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            cmd_sh_reg  <= cmd_sh_next;
            acc_reg     <= acc_next;
            mask_reg    <= mask_next;
            chan_reg    <= chan_next;
            sel_reg     <= sel_next;
            chip_reg    <= chip_next;
        end
    end

endmodule

/* sv/spi_adc_channel_scanner_core.sv */
// Top level of the serial converter channel scanner.
//
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   miso_level
//  out      output     out_valid/out_stall chip selects, mosi, pulse, reading
//  cfg      input      cfg_we              cfg_index, cfg_data
//
// Each tick passes through an input register, then through the sequencer
// step and the 12x32 scaling multiply into the output register.
// A new transaction is accepted every cycle while the output is taken.
// Reset puts the sequencer at the start tick of channel zero, both selects high.
// A stalled output holds; one more input transaction is buffered behind it.
module spi_adc_channel_scanner_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              miso_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              chip0_select_n,
    output logic                              chip1_select_n,
    output logic                              mosi_level,
    output logic                              clock_pulse,
    output logic                              reading_valid,
    output logic [scn_pkg::CH_W-1:0]          channel_index,
    output logic [scn_pkg::RAW_W-1:0]         raw_reading,
    output logic [scn_pkg::SCALED_W-1:0]      scaled_reading,
    input  logic                              cfg_we,
    input  logic [scn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scn_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import scn_pkg::*;
    `include "spi_adc_channel_scanner_core_defines.svh"

    cfg_t                cfg;
    tick_t               tick;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_miso_reg;
    logic                s1_adv;
    logic                in_acc;
    logic                out_valid_reg, out_valid_next;
    tick_t               out_tick_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic [SCALED_W-1:0] scaled_reg;

    // Configuration registers.
    scn_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage one moves on when the output register is free or being taken.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;

    // Sequencer, stepped once per tick leaving stage one.
    scn_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_adv),
        .miso  (s1_miso_reg),
        .cfg   (cfg),
        .tick  (tick)
    );

    // Scale the reading; raw is zero on ticks without a report.
    assign scaled_next = SCALED_W'(tick.raw_reading) * SCALED_W'(cfg.lsb_scale);

    // Valid bits of both stages.
    always_comb
    begin
        s1_valid_next = in_acc || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_miso_reg <= miso_level;
        end
        if (s1_adv)
        begin
            out_tick_reg <= tick;
            scaled_reg   <= scaled_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chip0_select_n = out_tick_reg.chip0_select_n;
    assign chip1_select_n = out_tick_reg.chip1_select_n;
    assign mosi_level     = out_tick_reg.mosi_level;
    assign clock_pulse    = out_tick_reg.clock_pulse;
    assign reading_valid  = out_tick_reg.reading_valid;
    assign channel_index  = out_tick_reg.channel_index;
    assign raw_reading    = out_tick_reg.raw_reading;
    assign scaled_reading = scaled_reg;

    // A clock pulse goes out with exactly one chip selected.
    `SCN_ASSERT_IMPLY(a_pulse_one_select, clk, rst_n, out_valid_reg && out_tick_reg.clock_pulse, out_tick_reg.chip0_select_n != out_tick_reg.chip1_select_n, "clock pulse without a single select")
    // A reading is reported with both selects released.
    `SCN_ASSERT_IMPLY(a_report_released, clk, rst_n, out_valid_reg && out_tick_reg.reading_valid, out_tick_reg.chip0_select_n && out_tick_reg.chip1_select_n, "reading reported while selected")
    // A tick leaving stage one shows up at the output next cycle.
    `SCN_ASSERT_NEXT(a_stage_to_output, clk, rst_n, s1_adv, out_valid_reg, "stage one tick lost")
    // Input is held off only when stage one is occupied.
    `SCN_ASSERT_IMPLY(a_stall_when_full, clk, rst_n, in_stall, s1_valid_reg, "stall with empty stage one")

endmodule

/* bench/spi_adc_channel_scanner_core_tb.sv */
// Self-checking testbench for the serial converter channel scanner core.
module spi_adc_channel_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scn_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(int'(REG_COMMAND_CH3) + 1);

    // How the data-out level is chosen for a stretch of transactions.
    typedef enum int {
        MISO_RANDOM,
        MISO_ONES,
        MISO_ZEROS
    } miso_mode_t;

    // One expected or observed output transaction.
    typedef struct packed {
        tick_t                seq;
        logic [SCALED_W-1:0]  scaled;
    } scan_out_t;

    // Tracks the sequencer state and holds the outputs still to come.
    class scan_tracker;
        scan_out_t            due_ticks[$];
        int                   errors;
        cfg_t                 regs;
        phase_t               phase;
        int                   bit_cnt;
        logic [CMD_W-1:0]     cmd_shift;
        logic [RAW_W-1:0]     acc;
        logic [DATA_BITS-1:0] mask;
        logic [CH_W-1:0]      chan;
        logic [1:0]           sel;
        logic                 chip;

        function new();
            errors         = 0;
            regs.lsb_scale = '0;
            regs.chip_map  = CHIP_MAP_RESET;
            regs.command   = '0;
            phase          = PH_START;
            bit_cnt        = 0;
            cmd_shift      = '0;
            acc            = '0;
            mask           = MASK_INIT;
            chan           = '0;
            sel            = 2'b11;
            chip           = 1'b0;
        endfunction

        function int outstanding();
            return due_ticks.size();
        endfunction

        // Mirror of a configuration write; unknown indexes change nothing.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_LSB_SCALE:   regs.lsb_scale = data;
                REG_CHIP_MAP:    regs.chip_map = data[MAP_W-1:0];
                REG_COMMAND_CH0: regs.command[0] = data[CMD_W-1:0];
                REG_COMMAND_CH1: regs.command[1] = data[CMD_W-1:0];
                REG_COMMAND_CH2: regs.command[2] = data[CMD_W-1:0];
                REG_COMMAND_CH3: regs.command[3] = data[CMD_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the sequencer by one tick and returns what the block shows.
        function scan_out_t next_tick(logic miso);
            scan_out_t   res;
            logic [63:0] prod;
            res = '0;
            case (phase)
                PH_SELECT:
                begin
                    sel[chip] = 1'b0;
                    phase = PH_CLOCK;
                end
                PH_CLOCK:
                begin
                    res.seq.clock_pulse = 1'b1;
                    if (bit_cnt < CMD_BITS)
                    begin
                        res.seq.mosi_level = cmd_shift[CMD_W-1];
                        cmd_shift = cmd_shift << 1;
                    end
                    if (bit_cnt >= DATA_START)
                    begin
                        if (miso)
                            acc = acc + mask;
                        mask = mask >> 1;
                    end
                    bit_cnt++;
                    if (bit_cnt >= CLOCKS_PER_READ)
                        phase = PH_RELEASE;
                end
                PH_RELEASE:
                begin
                    sel = 2'b11;
                    phase = PH_REPORT;
                end
                PH_REPORT:
                begin
                    prod = 64'(acc) * 64'(regs.lsb_scale);
                    res.seq.reading_valid = 1'b1;
                    res.seq.channel_index = chan;
                    res.seq.raw_reading   = acc;
                    res.scaled            = prod[SCALED_W-1:0];
                    phase = PH_ADVANCE;
                end
                PH_ADVANCE:
                begin
                    chan = (chan == CH_W'(CHANNELS - 1)) ? '0 : chan + 1'b1;
                    phase = PH_START;
                end
                default:
                begin
                    cmd_shift = regs.command[chan];
                    chip      = regs.chip_map[chan];
                    acc       = '0;
                    mask      = MASK_INIT;
                    bit_cnt   = 0;
                    phase     = PH_SELECT;
                end
            endcase
            res.seq.chip0_select_n = sel[0];
            res.seq.chip1_select_n = sel[1];
            return res;
        endfunction

        // Called for every accepted input transaction.
        function void note_miso(logic miso);
            due_ticks.push_back(next_tick(miso));
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // Called for every accepted output transaction.
        function void check_tick(scan_out_t got);
            scan_out_t want;
            if (due_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: output transaction mismatch: expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = due_ticks.pop_front();
            field_check("chip0_select_n", 64'(want.seq.chip0_select_n),
                        64'(got.seq.chip0_select_n));
            field_check("chip1_select_n", 64'(want.seq.chip1_select_n),
                        64'(got.seq.chip1_select_n));
            field_check("mosi_level", 64'(want.seq.mosi_level), 64'(got.seq.mosi_level));
            field_check("clock_pulse", 64'(want.seq.clock_pulse), 64'(got.seq.clock_pulse));
            field_check("reading_valid", 64'(want.seq.reading_valid),
                        64'(got.seq.reading_valid));
            field_check("channel_index", 64'(want.seq.channel_index),
                        64'(got.seq.channel_index));
            field_check("raw_reading", 64'(want.seq.raw_reading), 64'(got.seq.raw_reading));
            field_check("scaled_reading", 64'(want.scaled), 64'(got.scaled));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  miso_level;
    logic                  out_valid;
    logic                  out_stall;
    logic                  chip0_select_n;
    logic                  chip1_select_n;
    logic                  mosi_level;
    logic                  clock_pulse;
    logic                  reading_valid;
    logic [CH_W-1:0]       channel_index;
    logic [RAW_W-1:0]      raw_reading;
    logic [SCALED_W-1:0]   scaled_reading;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    scan_tracker tracker = new();

    int send_idle_pct = 12;
    int recv_idle_pct = 57;
    bit hold_request  = 1'b0;

    spi_adc_channel_scanner_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .miso_level     (miso_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chip0_select_n (chip0_select_n),
        .chip1_select_n (chip1_select_n),
        .mosi_level     (mosi_level),
        .clock_pulse    (clock_pulse),
        .reading_valid  (reading_valid),
        .channel_index  (channel_index),
        .raw_reading    (raw_reading),
        .scaled_reading (scaled_reading),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stall, or one long hold-off when requested.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Output monitor: every accepted output transaction is checked.
    initial
    begin : monitor
        scan_out_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.seq.chip0_select_n = chip0_select_n;
                got.seq.chip1_select_n = chip1_select_n;
                got.seq.mosi_level     = mosi_level;
                got.seq.clock_pulse    = clock_pulse;
                got.seq.reading_valid  = reading_valid;
                got.seq.channel_index  = channel_index;
                got.seq.raw_reading    = raw_reading;
                got.scaled             = scaled_reading;
                tracker.check_tick(got);
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one input transaction after a random gap; starts and ends at a falling edge.
    task automatic send_tick(input logic miso);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid   <= 1'b0;
            miso_level <= 1'($urandom_range(1));
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        miso_level <= miso;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_miso(miso);
        @(negedge clk);
    endtask

    // Stops offering input until every expected output has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Writes every register; optionally also the unused indexes, which must be ignored.
    task automatic program_regs(input logic [CFG_DAT_W-1:0] scale, input logic [CFG_DAT_W-1:0] map,
                                input logic [CFG_DAT_W-1:0] c0, input logic [CFG_DAT_W-1:0] c1,
                                input logic [CFG_DAT_W-1:0] c2, input logic [CFG_DAT_W-1:0] c3,
                                input bit spare);
        put_reg(REG_LSB_SCALE, scale);
        put_reg(REG_CHIP_MAP, map);
        put_reg(REG_COMMAND_CH0, c0);
        put_reg(REG_COMMAND_CH1, c1);
        put_reg(REG_COMMAND_CH2, c2);
        put_reg(REG_COMMAND_CH3, c3);
        if (spare)
        begin
            put_reg(FIRST_SPARE_REG, $urandom());
            put_reg(FIRST_SPARE_REG + 1'b1, $urandom());
        end
        cfg_we <= 1'b0;
    endtask

    // A stretch of input transactions with an optional long output hold and a mid-way drain.
    task automatic run_phase(input int count, input miso_mode_t mode, input bit long_hold,
                             input int pause_at);
        logic miso;
        for (int i = 0; i < count; i++)
        begin
            case (mode)
                MISO_ONES:  miso = 1'b1;
                MISO_ZEROS: miso = 1'b0;
                default:    miso = 1'($urandom_range(1));
            endcase
            if (long_hold && i == count / 3)
                hold_request = 1'b1;
            if (i == pause_at)
                drain();
            send_tick(miso);
        end
    endtask

    // Picks a register value, now and then one of the extremes.
    function automatic logic [CFG_DAT_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '1;
        if (r < 20)
            return '0;
        return $urandom();
    endfunction

    // Reset, directed part, then randomized phases under changing settings.
    initial
    begin : stimulus
        int         r;
        miso_mode_t mode;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        miso_level <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration with the data-out pin held high.
        send_idle_pct = 12;
        recv_idle_pct = 57;
        run_phase(25, MISO_ONES, 1'b0, -1);
        drain();

        // All registers at their maximum, full-scale reading, long output hold-off.
        program_regs('1, '1, '1, '1, '1, '1, 1'b1);
        run_phase(130, MISO_ONES, 1'b1, -1);
        drain();

        // All registers cleared.
        program_regs('0, '0, '0, '0, '0, '0, 1'b0);
        run_phase(130, MISO_RANDOM, 1'b0, -1);
        drain();

        // Scale of 2^24, mixed chips and alternating command patterns.
        program_regs(32'h0100_0000, 32'h5, 32'hAA, 32'h55, 32'h0F, 32'hF0, 1'b1);
        run_phase(130, MISO_RANDOM, 1'b0, -1);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = $urandom_range(99);
            mode = (r < 70) ? MISO_RANDOM : (r < 85) ? MISO_ONES : MISO_ZEROS;
            program_regs(pick_value(), pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value(), p == 2);
            run_phase(150, mode, 1'b0, (p == 1) ? 70 : -1);
            drain();
        end

        // Let any stray output transaction show up before the verdict.
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/scn_pkg.sv
sv/scn_cfg.sv
sv/scn_seq.sv
sv/spi_adc_channel_scanner_core.sv
bench/spi_adc_channel_scanner_core_tb.sv
